FILE: src/extent_list_address_translator_core_macros.svh
// Assertion macros shared by the checker of the extent list address translator.
`ifndef EXTENT_LIST_ADDRESS_TRANSLATOR_CORE_MACROS_SVH
`define EXTENT_LIST_ADDRESS_TRANSLATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ELAT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ELAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/elat_pkg.sv
// Types and constants shared by the extent list address translator modules.
package elat_pkg;

  localparam int SECTOR_SHIFT = 8;

  localparam int POS_W   = 24;
  localparam int START_W = 24;
  localparam int SECT_W  = 16;
  localparam int ADDR_W  = 33;
  localparam int IDX_IN_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 33;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK     = 2'd0;
  localparam status_t STAT_EOF    = 2'd1;
  localparam status_t STAT_PAST   = 2'd2;
  localparam status_t STAT_BEYOND = 2'd3;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SECT_W-1:0]  sectors;
  } seg_entry_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic    load;
    logic    capture;
    logic    rd_en;
    logic    rd_next;
    logic    acc;
    logic    calc;
    logic    addr;
    logic    push;
    logic    finish;
    status_t term;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic rem_zero;
    logic pos_eof;
    logic covered;
    logic table_done;
    logic walk_more;
  } sts_t;

endpackage

FILE: src/elat_ctrl.sv
// Sequencer of the extent list address translator: walk, chunk and finish control.
module elat_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            in_opcode,
  input  elat_pkg::sts_t  sts,
  output logic            busy,
  output elat_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_ADDR  = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_opcode == elat_pkg::OP_XLATE) begin
            cmd.capture = 1'b1;
            state_nxt = S_CHECK;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (sts.rem_zero) begin
          cmd.finish = 1'b1;
          cmd.term = elat_pkg::STAT_OK;
          state_nxt = S_IDLE;
        end else if (sts.pos_eof) begin
          cmd.finish = 1'b1;
          cmd.term = elat_pkg::STAT_EOF;
          state_nxt = S_IDLE;
        end else if (sts.covered) begin
          state_nxt = S_CALC;
        end else if (sts.table_done) begin
          cmd.finish = 1'b1;
          cmd.term = elat_pkg::STAT_PAST;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        // One table entry is added per cycle; the next read is issued alongside.
        cmd.acc = 1'b1;
        if (sts.walk_more) begin
          cmd.rd_en = 1'b1;
          cmd.rd_next = 1'b1;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        state_nxt = S_CHECK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/elat_dp.sv
// Datapath of the extent list address translator: segment memory, walk and chunk arithmetic.
module elat_dp #(
  parameter int SEG_MAX = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  elat_pkg::cmd_t                      cmd,
  output elat_pkg::sts_t                      sts,
  input  logic [elat_pkg::IDX_IN_W-1:0]       in_seg_index,
  input  logic [elat_pkg::START_W-1:0]        in_seg_start,
  input  logic [elat_pkg::SECT_W-1:0]         in_seg_sectors,
  input  logic [elat_pkg::POS_W-1:0]          in_position,
  input  logic [elat_pkg::POS_W-1:0]          in_request_length,
  input  logic                                cfg_we,
  input  logic [elat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [elat_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                out_valid,
  output logic [elat_pkg::ADDR_W-1:0]         out_disk_address,
  output logic [elat_pkg::POS_W-1:0]          out_chunk_bytes,
  output logic [elat_pkg::POS_W-1:0]          out_next_position,
  output elat_pkg::status_t                   out_status,
  output logic                                out_last
);

  localparam int IDX_W    = (SEG_MAX > 1) ? $clog2(SEG_MAX) : 1;
  localparam int IDXX_W   = (IDX_W > elat_pkg::IDX_IN_W) ? IDX_W : elat_pkg::IDX_IN_W;
  localparam int CNT_W    = $clog2(SEG_MAX + 1);
  localparam int SEGEND_W = elat_pkg::POS_W + $clog2(SEG_MAX + 1);
  localparam int TOP_W    = elat_pkg::START_W + 2;
  localparam int WADDR_W  = TOP_W + elat_pkg::SECTOR_SHIFT;
  localparam int POS_W    = elat_pkg::POS_W;

  // Configuration registers.
  logic [POS_W-1:0]                 file_size_r;
  logic [elat_pkg::SECT_W-1:0]      base_r;
  logic [elat_pkg::ADDR_W-1:0]      image_size_r;

  // Segment memory and its per-entry valid bits.
  elat_pkg::seg_entry_t             mem [SEG_MAX];
  logic [SEG_MAX-1:0]               vld_r;
  elat_pkg::seg_entry_t             rd_data_r;
  logic                             rd_vld_r;

  // Walk and chunk state.
  logic [POS_W-1:0]                 pos_r;
  logic [POS_W-1:0]                 rem_r;
  logic [SEGEND_W-1:0]              seg_end_r;
  logic [CNT_W-1:0]                 used_r;
  logic [POS_W-1:0]                 take_r;
  logic [POS_W-1:0]                 left_r;
  logic [TOP_W-1:0]                 seg_top_r;
  logic [WADDR_W-1:0]               ch_addr_r;

  // Result held back until it is known whether it is the last one.
  logic                             pend_vld_r;
  logic [elat_pkg::ADDR_W-1:0]      pend_addr_r;
  logic [POS_W-1:0]                 pend_bytes_r;
  logic [POS_W-1:0]                 pend_next_r;
  elat_pkg::status_t                pend_status_r;

  logic                             out_valid_r;
  logic [elat_pkg::ADDR_W-1:0]      out_addr_r;
  logic [POS_W-1:0]                 out_bytes_r;
  logic [POS_W-1:0]                 out_next_r;
  elat_pkg::status_t                out_status_r;
  logic                             out_last_r;

  logic [IDXX_W-1:0]                idx_wide;
  logic [IDX_W-1:0]                 wr_addr;
  logic                             wr_en;
  logic [CNT_W-1:0]                 used_inc;
  logic [CNT_W-1:0]                 used_sel;
  logic [IDX_W-1:0]                 rd_addr;
  logic [elat_pkg::START_W-1:0]     cur_start;
  logic [elat_pkg::SECT_W-1:0]      cur_len;
  logic [SEGEND_W-1:0]              pos_ext;
  logic [SEGEND_W-1:0]              seg_end_acc;
  logic [SEGEND_W-1:0]              left_full;
  logic [POS_W-1:0]                 fsz_left;
  logic [POS_W-1:0]                 take_a;
  logic [POS_W-1:0]                 take_c;
  logic                             ch_beyond;
  elat_pkg::status_t                fin_status;

  assign idx_wide = IDXX_W'(in_seg_index);
  assign wr_addr  = idx_wide[IDX_W-1:0];
  assign wr_en    = cmd.load && (32'(in_seg_index) < 32'(SEG_MAX));

  assign used_inc = used_r + CNT_W'(1);
  assign used_sel = cmd.rd_next ? used_inc : used_r;
  assign rd_addr  = used_sel[IDX_W-1:0];

  // An entry never loaded since reset reads as an empty segment at sector zero.
  assign cur_start = rd_vld_r ? rd_data_r.start : '0;
  assign cur_len   = rd_vld_r ? rd_data_r.sectors : '0;

  assign pos_ext     = SEGEND_W'(pos_r);
  assign seg_end_acc = seg_end_r + (SEGEND_W'(cur_len) << elat_pkg::SECTOR_SHIFT);

  assign sts.rem_zero   = (rem_r == '0);
  assign sts.pos_eof    = (pos_r >= file_size_r);
  assign sts.covered    = (seg_end_r > pos_ext);
  assign sts.table_done = (32'(used_r) >= 32'(SEG_MAX));
  assign sts.walk_more  = (seg_end_acc <= pos_ext) && (32'(used_inc) < 32'(SEG_MAX));

  // Chunk length is the smallest of what the file, the request and the segment allow.
  assign fsz_left  = file_size_r - pos_r;
  assign take_a    = (rem_r < fsz_left) ? rem_r : fsz_left;
  assign left_full = seg_end_r - pos_ext;
  assign take_c    = (left_full < SEGEND_W'(take_a)) ? left_full[POS_W-1:0] : take_a;

  assign ch_beyond  = (ch_addr_r > WADDR_W'(image_size_r));
  assign fin_status = (pend_status_r == elat_pkg::STAT_OK) ? cmd.term : pend_status_r;

  // Segment memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{start: in_seg_start, sectors: in_seg_sectors};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r  <= '0;
      base_r       <= elat_pkg::SECT_W'(32);
      image_size_r <= '0;
      vld_r        <= '0;
      rd_vld_r     <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          elat_pkg::CFG_FILE_SIZE:   file_size_r  <= cfg_wdata[POS_W-1:0];
          elat_pkg::CFG_BASE_OFFSET: base_r       <= cfg_wdata[elat_pkg::SECT_W-1:0];
          elat_pkg::CFG_IMAGE_SIZE:  image_size_r <= cfg_wdata[elat_pkg::ADDR_W-1:0];
          default: ;
        endcase
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (cmd.capture || cmd.finish) begin
        pend_vld_r <= 1'b0;
      end else if (cmd.push) begin
        pend_vld_r <= 1'b1;
      end
      out_valid_r <= cmd.finish || (cmd.push && pend_vld_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_r     <= in_position;
      rem_r     <= in_request_length;
      seg_end_r <= '0;
      used_r    <= '0;
    end
    if (cmd.acc) begin
      seg_end_r <= seg_end_acc;
      used_r    <= used_inc;
    end
    if (cmd.calc) begin
      take_r    <= take_c;
      left_r    <= left_full[POS_W-1:0];
      seg_top_r <= TOP_W'(cur_start) + TOP_W'(cur_len) + TOP_W'(base_r);
    end
    if (cmd.addr) begin
      ch_addr_r <= {seg_top_r, {elat_pkg::SECTOR_SHIFT{1'b0}}} - WADDR_W'(left_r);
      pos_r     <= pos_r + take_r;
      rem_r     <= rem_r - take_r;
    end
    if (cmd.push) begin
      pend_addr_r   <= ch_addr_r[elat_pkg::ADDR_W-1:0];
      pend_bytes_r  <= take_r;
      pend_next_r   <= pos_r;
      pend_status_r <= ch_beyond ? elat_pkg::STAT_BEYOND : elat_pkg::STAT_OK;
      out_addr_r    <= pend_addr_r;
      out_bytes_r   <= pend_bytes_r;
      out_next_r    <= pend_next_r;
      out_status_r  <= pend_status_r;
      out_last_r    <= 1'b0;
    end
    if (cmd.finish) begin
      out_last_r <= 1'b1;
      if (pend_vld_r) begin
        out_addr_r   <= pend_addr_r;
        out_bytes_r  <= pend_bytes_r;
        out_next_r   <= pend_next_r;
        out_status_r <= fin_status;
      end else begin
        out_addr_r   <= '0;
        out_bytes_r  <= '0;
        out_next_r   <= pos_r;
        out_status_r <= cmd.term;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_disk_address  = out_addr_r;
  assign out_chunk_bytes   = out_bytes_r;
  assign out_next_position = out_next_r;
  assign out_status        = out_status_r;
  assign out_last          = out_last_r;

endmodule

FILE: src/extent_list_address_translator_core.sv
// Top level of the extent list address translator: sequencer plus datapath.
//
// A load transaction writes one segment entry, if its index is below SEG_MAX, in
// the cycle it is accepted and returns nothing; busy stays low. A translate
// transaction raises busy and walks the segment table through the single read
// port of the segment memory, one entry per cycle, then computes each chunk
// through the check, calc, addr and push states. The walk covers at most SEG_MAX
// entries. Each result is held one chunk back so that the last one can be
// flagged; results appear on out_valid for one cycle each and must be taken
// then, since the block has no way to be stalled. The segment table reads as
// all zero after reset with no clearing pass. Configuration is to be written
// by the user while busy is low; the block itself does not enforce it.
module extent_list_address_translator_core #(
  parameter int SEG_MAX = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_opcode,
  input  logic [elat_pkg::IDX_IN_W-1:0]    in_seg_index,
  input  logic [elat_pkg::START_W-1:0]     in_seg_start,
  input  logic [elat_pkg::SECT_W-1:0]      in_seg_sectors,
  input  logic [elat_pkg::POS_W-1:0]       in_position,
  input  logic [elat_pkg::POS_W-1:0]       in_request_length,
  output logic                             out_valid,
  output logic [elat_pkg::ADDR_W-1:0]      out_disk_address,
  output logic [elat_pkg::POS_W-1:0]       out_chunk_bytes,
  output logic [elat_pkg::POS_W-1:0]       out_next_position,
  output logic [1:0]                       out_status,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [elat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [elat_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  elat_pkg::cmd_t    cmd;
  elat_pkg::sts_t    sts;
  elat_pkg::status_t status_w;

  elat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  elat_dp #(
    .SEG_MAX (SEG_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_seg_index      (in_seg_index),
    .in_seg_start      (in_seg_start),
    .in_seg_sectors    (in_seg_sectors),
    .in_position       (in_position),
    .in_request_length (in_request_length),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_disk_address  (out_disk_address),
    .out_chunk_bytes   (out_chunk_bytes),
    .out_next_position (out_next_position),
    .out_status        (status_w),
    .out_last          (out_last)
  );

  assign out_status = status_w;

endmodule

FILE: src/elat_chk.sv
// Port-level checker for the extent list address translator, bound to the top level.
`include "extent_list_address_translator_core_macros.svh"

module elat_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            in_opcode,
  input logic                            out_valid,
  input logic [elat_pkg::ADDR_W-1:0]     out_disk_address,
  input logic [elat_pkg::POS_W-1:0]      out_chunk_bytes,
  input logic [1:0]                      out_status,
  input logic                            out_last
);

  // A transaction that is not the last one is always followed by more work.
  `ELAT_ASSERT_SAME(a_mid_busy, out_valid && !out_last, busy, "intermediate result while idle")
  // Only the no-chunk result carries zero bytes, and it is always last and at address zero.
  `ELAT_ASSERT_SAME(a_empty_last, out_valid && (out_chunk_bytes == '0), out_last && (out_disk_address == '0), "empty result not final")
  // End of file and table exhaustion are only ever reported on the final result.
  `ELAT_ASSERT_SAME(a_mid_status, out_valid && !out_last, (out_status == elat_pkg::STAT_OK) || (out_status == elat_pkg::STAT_BEYOND), "terminal status on intermediate result")
  // A load completes at once and leaves the block idle.
  `ELAT_ASSERT_NEXT(a_load_idle, start && !busy && (in_opcode == elat_pkg::OP_LOAD), !busy && !out_valid, "load did not complete at once")
  // A translate always raises busy.
  `ELAT_ASSERT_NEXT(a_xlate_busy, start && !busy && (in_opcode == elat_pkg::OP_XLATE), busy, "translate did not start")

endmodule

bind extent_list_address_translator_core elat_chk u_elat_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_opcode        (in_opcode),
  .out_valid        (out_valid),
  .out_disk_address (out_disk_address),
  .out_chunk_bytes  (out_chunk_bytes),
  .out_status       (out_status),
  .out_last         (out_last)
);

FILE: sim/chunk_ledger_pkg.sv
// Chunk prediction and checking for the extent list address translator testbench.
package chunk_ledger_pkg;
  import elat_pkg::*;

  localparam int SEG_COUNT = 48;

  // One input transaction, field for field as on the in_ ports.
  typedef struct packed {
    logic                opcode;
    logic [IDX_IN_W-1:0] seg_index;
    logic [START_W-1:0]  seg_start;
    logic [SECT_W-1:0]   seg_sectors;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    request_length;
  } xfer_t;

  // One result transaction, in the order of the out_ ports.
  typedef struct packed {
    logic [ADDR_W-1:0] disk_address;
    logic [POS_W-1:0]  chunk_bytes;
    logic [POS_W-1:0]  next_position;
    status_t           status;
    logic              last;
  } chunk_t;

  class chunk_ledger;
    logic [POS_W-1:0]   file_len;
    logic [SECT_W-1:0]  base_sectors;
    logic [ADDR_W-1:0]  image_limit;
    logic [START_W-1:0] seg_first [SEG_COUNT];
    logic [SECT_W-1:0]  seg_count [SEG_COUNT];
    chunk_t             pending_chunks [$];
    int                 mismatches;

    function new();
      file_len     = '0;
      base_sectors = 16'd32;
      image_limit  = '0;
      mismatches   = 0;
      foreach (seg_first[i]) begin
        seg_first[i] = '0;
        seg_count[i] = '0;
      end
    endfunction

    function void set_config(logic [POS_W-1:0] fs, logic [SECT_W-1:0] base,
                             logic [ADDR_W-1:0] img);
      file_len     = fs;
      base_sectors = base;
      image_limit  = img;
    endfunction

    function int pending();
      return pending_chunks.size();
    endfunction

    // Updates the segment table for a load, or queues the chunks a translate yields.
    function void note_request(xfer_t t);
      logic [63:0] pos, rem, seg_end, take, left, addr;
      int unsigned used;
      status_t     term;
      chunk_t      c;
      chunk_t      run [$];
      if (t.opcode == OP_LOAD) begin
        if (t.seg_index < SEG_COUNT) begin
          seg_first[t.seg_index] = t.seg_start;
          seg_count[t.seg_index] = t.seg_sectors;
        end
        return;
      end
      pos     = 64'(t.position);
      rem     = 64'(t.request_length);
      seg_end = '0;
      used    = 0;
      term    = STAT_OK;
      while (rem > 0) begin
        if (pos >= 64'(file_len)) begin
          term = STAT_EOF;
          break;
        end
        take = 64'(file_len) - pos;
        if (rem < take) take = rem;
        // Advance over segments until one ends beyond the position; empty ones add nothing.
        while (seg_end <= pos && term == STAT_OK) begin
          if (used >= SEG_COUNT) begin
            term = STAT_PAST;
          end else begin
            seg_end = seg_end + (64'(seg_count[used]) << SECTOR_SHIFT);
            used++;
          end
        end
        if (term != STAT_OK) break;
        left = seg_end - pos;
        if (left < take) take = left;
        addr = ((64'(seg_first[used-1]) + 64'(seg_count[used-1])) << SECTOR_SHIFT)
               - left + (64'(base_sectors) << SECTOR_SHIFT);
        pos = pos + take;
        rem = rem - take;
        c.disk_address  = addr[ADDR_W-1:0];
        c.chunk_bytes   = take[POS_W-1:0];
        c.next_position = pos[POS_W-1:0];
        c.status        = (addr > 64'(image_limit)) ? STAT_BEYOND : STAT_OK;
        c.last          = 1'b0;
        run.push_back(c);
      end
      if (run.size() == 0) begin
        c.disk_address  = '0;
        c.chunk_bytes   = '0;
        c.next_position = pos[POS_W-1:0];
        c.status        = term;
        c.last          = 1'b0;
      end else begin
        c = run.pop_back();
        if (c.status == STAT_OK) c.status = term;
      end
      c.last = 1'b1;
      run.push_back(c);
      foreach (run[i]) pending_chunks.push_back(run[i]);
    endfunction

    function void check_chunk(chunk_t got);
      chunk_t want;
      if (pending_chunks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected chunk: addr %h bytes %h next %h status %0d last %b",
                   got.disk_address, got.chunk_bytes, got.next_position, got.status,
                   got.last);
        return;
      end
      want = pending_chunks.pop_front();
      if (got.disk_address !== want.disk_address || got.chunk_bytes !== want.chunk_bytes ||
          got.next_position !== want.next_position || got.status !== want.status ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("chunk mismatch: expected addr %h bytes %h next %h status %0d last %b",
                   want.disk_address, want.chunk_bytes, want.next_position, want.status,
                   want.last);
          $display("                actual   addr %h bytes %h next %h status %0d last %b",
                   got.disk_address, got.chunk_bytes, got.next_position, got.status,
                   got.last);
        end
      end
    endfunction
  endclass

endpackage

FILE: sim/extent_list_address_translator_core_tb.sv
// Testbench top for the extent list address translator core.
module extent_list_address_translator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import elat_pkg::*;
  import chunk_ledger_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 25;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_opcode;
  logic [IDX_IN_W-1:0]   in_seg_index;
  logic [START_W-1:0]    in_seg_start;
  logic [SECT_W-1:0]     in_seg_sectors;
  logic [POS_W-1:0]      in_position;
  logic [POS_W-1:0]      in_request_length;
  logic                  out_valid;
  logic [ADDR_W-1:0]     out_disk_address;
  logic [POS_W-1:0]      out_chunk_bytes;
  logic [POS_W-1:0]      out_next_position;
  logic [1:0]            out_status;
  logic                  out_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  chunk_ledger ledger;
  int          burst_left;

  extent_list_address_translator_core #(.SEG_MAX(SEG_COUNT)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_seg_index     (in_seg_index),
    .in_seg_start     (in_seg_start),
    .in_seg_sectors   (in_seg_sectors),
    .in_position      (in_position),
    .in_request_length(in_request_length),
    .out_valid        (out_valid),
    .out_disk_address (out_disk_address),
    .out_chunk_bytes  (out_chunk_bytes),
    .out_next_position(out_next_position),
    .out_status       (out_status),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      ledger.check_chunk(chunk_t'({out_disk_address, out_chunk_bytes, out_next_position,
                                   out_status, out_last}));
  end

  function automatic xfer_t load_item(int idx, logic [START_W-1:0] first,
                                      logic [SECT_W-1:0] count);
    xfer_t t;
    t.opcode         = OP_LOAD;
    t.seg_index      = idx[IDX_IN_W-1:0];
    t.seg_start      = first;
    t.seg_sectors    = count;
    t.position       = POS_W'($urandom);
    t.request_length = POS_W'($urandom);
    return t;
  endfunction

  function automatic xfer_t xlate_item(logic [POS_W-1:0] pos, logic [POS_W-1:0] len);
    xfer_t t;
    t.opcode         = OP_XLATE;
    t.seg_index      = IDX_IN_W'($urandom);
    t.seg_start      = START_W'($urandom);
    t.seg_sectors    = SECT_W'($urandom);
    t.position       = pos;
    t.request_length = len;
    return t;
  endfunction

  // Mostly small segments and requests inside the file, with some full-range noise.
  function automatic xfer_t random_item(logic [POS_W-1:0] fs);
    int               pick;
    logic [POS_W-1:0] span, pos, len;
    pick = int'($urandom_range(0, 99));
    if (pick < 30) return load_item(int'($urandom_range(0, SEG_COUNT - 1)),
                                    START_W'($urandom), SECT_W'($urandom_range(0, 6)));
    if (pick < 36) return load_item(int'($urandom_range(0, 63)), START_W'($urandom),
                                    SECT_W'($urandom));
    span = (fs < 24'd60000) ? fs : 24'd60000;
    pick = int'($urandom_range(0, 99));
    if (pick < 70) pos = POS_W'($urandom_range(0, span));
    else if (pick < 85) pos = POS_W'($urandom);
    else pos = fs - POS_W'($urandom_range(0, 3));
    pick = int'($urandom_range(0, 99));
    if (pick < 10) len = '0;
    else if (pick < 65) len = POS_W'($urandom_range(1, 3000));
    else if (pick < 85) len = POS_W'($urandom_range(3000, 70000));
    else len = POS_W'($urandom);
    return xlate_item(pos, len);
  endfunction

  task automatic send(input xfer_t t);
    in_opcode         <= t.opcode;
    in_seg_index      <= t.seg_index;
    in_seg_start      <= t.seg_start;
    in_seg_sectors    <= t.seg_sectors;
    in_position       <= t.position;
    in_request_length <= t.request_length;
    start             <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    ledger.note_request(t);
  endtask

  task automatic idle(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      idle(int'($urandom_range(1, 12)));
      burst_left = int'($urandom_range(1, 10));
    end
    burst_left--;
  endtask

  // Waits for every expected chunk and for the block to go idle, plus a short margin.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_config(input logic [POS_W-1:0] fs, input logic [SECT_W-1:0] base,
                                input logic [ADDR_W-1:0] img);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FILE_SIZE;
    cfg_wdata <= CFG_DATA_W'(fs);
    @(posedge clk);
    cfg_index <= CFG_BASE_OFFSET;
    cfg_wdata <= CFG_DATA_W'(base);
    @(posedge clk);
    cfg_index <= CFG_IMAGE_SIZE;
    cfg_wdata <= img;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_config(fs, base, img);
  endtask

  initial begin
    xfer_t             t;
    logic [POS_W-1:0]  fs;
    logic [SECT_W-1:0] base;
    logic [ADDR_W-1:0] img;
    int                counted;
    ledger            = new();
    rst_n             = 1'b0;
    start             = 1'b0;
    in_opcode         = OP_LOAD;
    in_seg_index      = '0;
    in_seg_start      = '0;
    in_seg_sectors    = '0;
    in_position       = '0;
    in_request_length = '0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_FILE_SIZE;
    cfg_wdata         = '0;
    burst_left        = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: empty file, so a zero-length request and end of file at once.
    send(xlate_item(24'd0, 24'd0));
    send(xlate_item(24'd5, 24'd100));
    settle();
    program_config(24'hFFFFFF, 16'd0, 33'h1FFFFFFFF);
    // All-zero table: the walk runs off the table before any chunk.
    send(xlate_item(24'd0, 24'd10));
    send(load_item(0, 24'hFFFFFF, 16'd1));
    send(load_item(1, 24'd0, 16'd0));
    send(load_item(2, 24'd100, 16'd2));
    send(load_item(47, 24'h123456, 16'hFFFF));
    send(load_item(63, 24'hABCDEF, 16'd3));
    send(load_item(48, 24'h000001, 16'd4));
    send(xlate_item(24'd0, 24'hFFFFFF));
    send(xlate_item(24'd300, 24'd100));
    send(xlate_item(24'hFFFFFF, 24'd1));
    send(xlate_item(24'd255, 24'd2));
    settle();
    // Large offset against a zero image size: every chunk lies beyond the image.
    program_config(24'd1000, 16'hFFFF, 33'd0);
    send(xlate_item(24'd0, 24'd2000));
    send(xlate_item(24'd999, 24'd1));
    settle();
    program_config(24'hFFFFFF, 16'd32, 33'h1FFFFFFFF);
    send(load_item(47, 24'd5, 16'd0));
    send(xlate_item(24'd500, 24'd1000));
    send(xlate_item(24'd768, 24'd5));

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        fs   = 24'hFFFFFF;
        base = 16'hFFFF;
        img  = 33'h1FFFFFFFF;
      end else if (ph == 1) begin
        fs   = '0;
        base = '0;
        img  = '0;
      end else begin
        case ($urandom_range(0, 3))
          0:       fs = POS_W'($urandom_range(0, 70000));
          1:       fs = POS_W'($urandom);
          2:       fs = 24'hFFFFFF;
          default: fs = POS_W'($urandom_range(1000, 20000));
        endcase
        case ($urandom_range(0, 2))
          0:       base = '0;
          1:       base = 16'hFFFF;
          default: base = SECT_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0:       img = '0;
          1:       img = 33'h1FFFFFFFF;
          2:       img = {1'($urandom_range(0, 1)), 32'($urandom)};
          default: img = 33'($urandom_range(0, 32'h7FFFFFFF));
        endcase
      end
      program_config(fs, base, img);
      // One phase runs back to back with no gaps at all.
      burst_left = (ph == 2) ? 1000000 : 0;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        t = random_item(fs);
        pace();
        send(t);
        if (!(t.opcode == OP_LOAD && t.seg_index >= SEG_COUNT)) counted++;
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
